[design/rgb_to_hsi_color_mask_assert.svh]
// ----------------------------------------------------------------------------
// RGB to HSI colour mask: assertion macros
// Shared macros for the concurrent checks of the colour mask design. The
// checks sample on clk and are disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSI_COLOR_MASK_ASSERT_SVH
`define RGB_TO_HSI_COLOR_MASK_ASSERT_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define RTHCM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RTHCM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define RTHCM_ASSERT_IMP(lbl, ante, cons, msg)
`define RTHCM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[design/rthcm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSI colour mask: shared package
// Widths, constants, register indexes and the divider request type used by
// the colour mask top level and its hue divider.
// ----------------------------------------------------------------------------
package rthcm_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HUE_LOWER = 3'd0,
		CFG_HUE_UPPER = 3'd1,
		CFG_INT_LOWER = 3'd2,
		CFG_INT_UPPER = 3'd3,
		CFG_SAT_LOWER = 3'd4,
		CFG_SAT_UPPER = 3'd5
	} cfg_idx_t;

	// Reset values of the bounds.
	localparam logic [7:0] RST_HUE_LOWER = 8'd35;
	localparam logic [7:0] RST_HUE_UPPER = 8'd55;
	localparam logic [7:0] RST_INT_LOWER = 8'd30;
	localparam logic [7:0] RST_INT_UPPER = 8'd127;
	localparam logic [7:0] RST_SAT_LOWER = 8'd0;
	localparam logic [7:0] RST_SAT_UPPER = 8'd127;

	// Hue constants.
	localparam logic [7:0] NO_COLOUR_HUE = 8'd255;
	localparam logic [5:0] SECTOR_STEP   = 6'd42;
	localparam logic [7:0] HUE_BASE_RED   = 8'd42;
	localparam logic [7:0] HUE_BASE_GREEN = 8'd126;
	localparam logic [7:0] HUE_BASE_BLUE  = 8'd210;

	// Dividend is 42 * |difference| <= 10710, quotient never exceeds 42.
	localparam int DIVD_W  = 14;
	localparam int DIV_Q_W = 6;

	// Channel sum and the reciprocal of three: (sum * 683) >> 11 is exact
	// for every sum up to 765.
	localparam int          SUM_W       = 10;
	localparam logic [9:0]  RECIP_THIRD = 10'd683;
	localparam int          RECIP_SHIFT = 11;

	typedef struct packed {
		logic [DIVD_W-1:0] dividend;
		logic [7:0]        divisor;
	} div_in_t;

endpackage

[design/rthcm_hue_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSI colour mask: pipelined hue divider
// Restoring division of the scaled channel difference by the spread, two
// quotient bits per stage over three stages. A new request may enter every
// cycle; each request's quotient is registered through stages s3, s4 and s5.
// ----------------------------------------------------------------------------
module rthcm_hue_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_vld,
	input  rthcm_pkg::div_in_t                   req,
	output logic                                 quo_vld,
	output logic [rthcm_pkg::DIV_Q_W-1:0]        quotient
);
	import rthcm_pkg::*;

	typedef struct packed {
		logic [DIVD_W-1:0] rem;
		logic              bit_q;
	} div_step_t;

	// One restoring step: try to take divisor << k off the remainder.
	function automatic div_step_t div_step(input logic [DIVD_W-1:0] rem,
					       input logic [7:0] dsr,
					       input logic [2:0] k);
		div_step_t         res;
		logic [DIVD_W-1:0] trial;
		trial     = {{(DIVD_W-8){1'b0}}, dsr} << k;
		res.bit_q = (rem >= trial);
		res.rem   = res.bit_q ? (rem - trial) : rem;
		return res;
	endfunction

	logic              vld_s3, vld_s4, vld_s5;
	logic [DIVD_W-1:0] rem_s3, rem_s4;
	logic [7:0]        dsr_s3, dsr_s4;
	logic [1:0]        quo_s3;
	logic [3:0]        quo_s4;
	logic [5:0]        quo_s5;

	div_step_t st5, st4, st3, st2, st1, st0;

	always_comb begin
		st5 = div_step(req.dividend, req.divisor, 3'd5);
		st4 = div_step(st5.rem, req.divisor, 3'd4);
		st3 = div_step(rem_s3, dsr_s3, 3'd3);
		st2 = div_step(st3.rem, dsr_s3, 3'd2);
		st1 = div_step(rem_s4, dsr_s4, 3'd1);
		st0 = div_step(st1.rem, dsr_s4, 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s3 <= req_vld;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		rem_s3 <= st4.rem;
		dsr_s3 <= req.divisor;
		quo_s3 <= {st5.bit_q, st4.bit_q};
		rem_s4 <= st2.rem;
		dsr_s4 <= dsr_s3;
		quo_s4 <= {quo_s3, st3.bit_q, st2.bit_q};
		quo_s5 <= {quo_s4, st1.bit_q, st0.bit_q};
	end

	assign quo_vld  = vld_s5;
	assign quotient = quo_s5;

endmodule

[design/rgb_to_hsi_color_mask.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSI colour mask: top level
// Converts one 8-bit RGB pixel per clock while busy is low into hue,
// saturation and intensity; mask is high unless it is strictly in bounds.
// ----------------------------------------------------------------------------
// A pixel transaction is taken at every rising edge with start high and busy
// low; busy is high only in the first cycle after reset is released, so the
// block takes one pixel per clock from then on. Each pixel gives exactly one
// result transaction, registered through every pipeline stage and shown for
// one cycle with done high. The receiver cannot hold results off and none is
// needed: the pipeline never stalls. The hue divider resolves two quotient
// bits in each of its three stages; the other stages find the extremes,
// scale the difference, and form the final hue and the mask. The bounds
// registers should only be written while no pixel is in flight.
// ----------------------------------------------------------------------------
module rgb_to_hsi_color_mask (
	input  logic                              clk,
	input  logic                              arst_n,
	// Pixel transaction.
	input  logic                              start,
	output logic                              busy,
	input  logic [7:0]                        red,
	input  logic [7:0]                        green,
	input  logic [7:0]                        blue,
	// Result transaction.
	output logic                              done,
	output logic [7:0]                        hue,
	output logic                              saturation,
	output logic [7:0]                        intensity,
	output logic                              mask,
	// Bounds register write port.
	input  logic                              cfg_wr_en,
	input  logic [rthcm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [7:0]                        cfg_wdata
);
	import rthcm_pkg::*;

	`include "rgb_to_hsi_color_mask_assert.svh"

	// Information that travels beside the divider.
	typedef struct packed {
		logic [7:0] base;
		logic       neg;
		logic       no_colour;
		logic [7:0] intensity;
		logic       sat;
	} side_t;

	logic busy_q;
	logic accept;

	logic [7:0] hue_lower_q, hue_upper_q;
	logic [7:0] int_lower_q, int_upper_q;
	logic [7:0] sat_lower_q, sat_upper_q;

	// The bounds registers. Indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_lower_q <= RST_HUE_LOWER;
			hue_upper_q <= RST_HUE_UPPER;
			int_lower_q <= RST_INT_LOWER;
			int_upper_q <= RST_INT_UPPER;
			sat_lower_q <= RST_SAT_LOWER;
			sat_upper_q <= RST_SAT_UPPER;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_HUE_LOWER: hue_lower_q <= cfg_wdata;
				CFG_HUE_UPPER: hue_upper_q <= cfg_wdata;
				CFG_INT_LOWER: int_lower_q <= cfg_wdata;
				CFG_INT_UPPER: int_upper_q <= cfg_wdata;
				CFG_SAT_LOWER: sat_lower_q <= cfg_wdata;
				CFG_SAT_UPPER: sat_upper_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Busy covers the cycle straight after reset so that the first pixel
	// meets a settled pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy   = busy_q;
	assign accept = start && !busy_q;

	// Stage 1: extremes, spread, the sector of the largest channel and the
	// signed difference that belongs to it. Ties go to red, then green.
	logic              vld_s1;
	logic [7:0]        max_s1, spread_s1, base_s1;
	logic signed [8:0] diff_s1;
	logic [SUM_W-1:0]  sum_s1;

	logic              r_top, g_top;
	logic [7:0]        max_c, min_c, base_c;
	logic signed [8:0] diff_c;

	always_comb begin
		r_top  = (red >= green) && (red >= blue);
		g_top  = !r_top && (green >= blue);
		max_c  = r_top ? red : (g_top ? green : blue);
		min_c  = red;
		if (green < min_c) begin
			min_c = green;
		end
		if (blue < min_c) begin
			min_c = blue;
		end
		if (r_top) begin
			base_c = HUE_BASE_RED;
			diff_c = $signed({1'b0, green}) - $signed({1'b0, blue});
		end else if (g_top) begin
			base_c = HUE_BASE_GREEN;
			diff_c = $signed({1'b0, blue}) - $signed({1'b0, red});
		end else begin
			base_c = HUE_BASE_BLUE;
			diff_c = $signed({1'b0, red}) - $signed({1'b0, green});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		max_s1    <= max_c;
		spread_s1 <= max_c - min_c;
		base_s1   <= base_c;
		diff_s1   <= diff_c;
		sum_s1    <= {2'b00, red} + {2'b00, green} + {2'b00, blue};
	end

	// Stage 2: scale the difference magnitude by the sector step, test for
	// grey, and divide the sum by three through the reciprocal.
	logic               vld_s2;
	div_in_t            div_req_s2;
	side_t              side_s2;

	logic [7:0]               diff_abs;
	logic [2*SUM_W-1:0]       third_prod;

	always_comb begin
		diff_abs   = diff_s1[8] ? 8'(-diff_s1) : diff_s1[7:0];
		third_prod = {{SUM_W{1'b0}}, sum_s1} * {{SUM_W{1'b0}}, RECIP_THIRD};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		div_req_s2.dividend <= {{(DIVD_W-8){1'b0}}, diff_abs}
				     * {{(DIVD_W-6){1'b0}}, SECTOR_STEP};
		div_req_s2.divisor  <= spread_s1;
		side_s2.base        <= base_s1;
		side_s2.neg         <= diff_s1[8];
		// A zero spread always lands here, so the divider's answer for a
		// zero divisor is never used.
		side_s2.no_colour   <= ({spread_s1, 1'b0} <= {1'b0, max_s1});
		side_s2.intensity   <= third_prod[RECIP_SHIFT+7:RECIP_SHIFT];
		side_s2.sat         <= (sum_s1 != '0);
	end

	// Stages 3 to 5: the divider, with the side information alongside.
	logic                quo_vld;
	logic [DIV_Q_W-1:0]  quotient;
	side_t               side_s3, side_s4, side_s5;

	rthcm_hue_div u_hue_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_vld  (vld_s2),
		.req      (div_req_s2),
		.quo_vld  (quo_vld),
		.quotient (quotient)
	);

	always_ff @(posedge clk) begin
		side_s3 <= side_s2;
		side_s4 <= side_s3;
		side_s5 <= side_s4;
	end

	// Stage 6: the signed quotient is folded into the sector base, which
	// is truncation toward zero since the magnitude was divided. The mask
	// then compares against the bounds.
	logic       done_s6;
	logic [7:0] hue_s6, intensity_s6;
	logic       sat_s6, mask_s6;

	logic [7:0] quo_ext, hue_c;
	logic       match_c;

	always_comb begin
		quo_ext = {{(8-DIV_Q_W){1'b0}}, quotient};
		if (side_s5.no_colour) begin
			hue_c = NO_COLOUR_HUE;
		end else if (side_s5.neg) begin
			hue_c = side_s5.base - quo_ext;
		end else begin
			hue_c = side_s5.base + quo_ext;
		end
		match_c = (hue_c > hue_lower_q) && (hue_c < hue_upper_q)
			&& (side_s5.intensity > int_lower_q)
			&& (side_s5.intensity < int_upper_q)
			&& ({7'd0, side_s5.sat} > sat_lower_q)
			&& ({7'd0, side_s5.sat} < sat_upper_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s6 <= 1'b0;
		end else begin
			done_s6 <= quo_vld;
		end
	end

	always_ff @(posedge clk) begin
		hue_s6       <= hue_c;
		intensity_s6 <= side_s5.intensity;
		sat_s6       <= side_s5.sat;
		mask_s6      <= !match_c;
	end

	assign done       = done_s6;
	assign hue        = hue_s6;
	assign saturation = sat_s6;
	assign intensity  = intensity_s6;
	assign mask       = mask_s6;

	// Every pixel taken gives a result, and no result appears without one.
	`RTHCM_ASSERT_IMP(a_result_follows, accept, ##6 done, "pixel lost in the pipeline")
	`RTHCM_ASSERT_IMP(a_no_stray_result, done, $past(accept, 6), "result without a pixel")
	// A coloured hue never leaves the sector range.
	`RTHCM_ASSERT_IMP(a_hue_range, done && (hue != NO_COLOUR_HUE), hue <= 8'd252,
		"hue outside the sector range")
	// A black pixel is grey with zero intensity.
	`RTHCM_ASSERT_IMP(a_black_pixel, done && !saturation,
		(hue == NO_COLOUR_HUE) && (intensity == 8'd0), "black pixel not grey")
	// Busy only ever covers the cycle after reset.
	`RTHCM_ASSERT_NEXT(a_busy_once, !busy, !busy, "busy raised after reset")

endmodule

[dv/tb_rgb_to_hsi_color_mask.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSI colour mask: testbench
// Drives pixel transactions into the colour mask block through a queued
// driver. It predicts hue, saturation, intensity and the mask bit for every
// accepted pixel and checks each result transaction against the oldest
// prediction. The bounds registers are reprogrammed between phases while the
// block is idle.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsi_color_mask;
	import rthcm_pkg::*;

	// Hue of a pixel with no colour, and the width of one hue sector.
	localparam int GREY_HUE   = 255;
	localparam int HUE_SECTOR = 42;

	// Register indexes with no register behind them; writes to them must be ignored.
	localparam logic [CFG_IDX_W-1:0] SPARE_IDX_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] SPARE_IDX_HI = 3'd7;

	// Idle time given to the pipeline after the last result, before the bounds change.
	localparam int PIPE_SETTLE = 10;
	// Cycles without any transaction or register write before the run is abandoned.
	localparam int QUIET_LIMIT = 2000;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} pixel_t;

	typedef struct packed {
		logic [7:0] hue;
		logic       saturation;
		logic [7:0] intensity;
		logic       mask;
	} hsi_t;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 start      = 1'b0;
	logic [7:0]           red        = 8'd0;
	logic [7:0]           green      = 8'd0;
	logic [7:0]           blue       = 8'd0;
	logic                 cfg_wr_en  = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index  = '0;
	logic [7:0]           cfg_wdata  = 8'd0;
	logic                 busy;
	logic                 done;
	logic [7:0]           hue;
	logic                 saturation;
	logic [7:0]           intensity;
	logic                 mask;

	// Pixels waiting to be driven, and the results owed by the block in order.
	pixel_t pixel_q[$];
	hsi_t   result_due_q[$];

	// The testbench's own copy of the six bounds registers.
	logic [7:0] bound_reg [6];

	int gap_pct;
	int gap_left;
	int err_count;
	int quiet_cycles;

	rgb_to_hsi_color_mask i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.done       (done),
		.hue        (hue),
		.saturation (saturation),
		.intensity  (intensity),
		.mask       (mask),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	always #5 clk = ~clk;

	// True when the value lies strictly between the two bounds; an inverted or
	// empty pair of bounds can never match.
	function automatic bit between_excl(int value, logic [7:0] lo, logic [7:0] hi);
		return value > int'(lo) && value < int'(hi);
	endfunction

	// Integer RGB to HSI conversion and bounds test for one pixel, using the
	// bounds held at the moment the pixel is accepted.
	function automatic hsi_t hsi_of_pixel(pixel_t px);
		int   r, g, b;
		int   top, bottom, spread, total, h;
		hsi_t res;
		r = px.r;
		g = px.g;
		b = px.b;
		top = r;
		bottom = r;
		if (g > top) top = g;
		if (b > top) top = b;
		if (g < bottom) bottom = g;
		if (b < bottom) bottom = b;
		spread = top - bottom;
		total = r + g + b;
		// A flat pixel has a spread of zero and always lands here, so the
		// division below never sees a zero divisor.
		if (2 * spread <= top) begin
			res.hue = GREY_HUE[7:0];
		end else begin
			// Ties go to red first, then to green. Signed division truncates
			// toward zero, which is what the block must do as well.
			if (r == top) begin
				h = HUE_SECTOR + (HUE_SECTOR * (g - b)) / spread;
			end else if (g == top) begin
				h = 3 * HUE_SECTOR + (HUE_SECTOR * (b - r)) / spread;
			end else begin
				h = 5 * HUE_SECTOR + (HUE_SECTOR * (r - g)) / spread;
			end
			res.hue = h[7:0];
		end
		res.saturation = (total != 0);
		res.intensity  = 8'(total / 3);
		res.mask = !(between_excl(res.hue, bound_reg[CFG_HUE_LOWER], bound_reg[CFG_HUE_UPPER])
			&& between_excl(res.intensity, bound_reg[CFG_INT_LOWER], bound_reg[CFG_INT_UPPER])
			&& between_excl(res.saturation, bound_reg[CFG_SAT_LOWER],
				bound_reg[CFG_SAT_UPPER]));
		return res;
	endfunction

	task automatic queue_pixel(int r, int g, int b);
		pixel_t px;
		px.r = 8'(r);
		px.g = 8'(g);
		px.b = 8'(b);
		pixel_q.push_back(px);
	endtask

	// Random pixels, weighted towards the places where the hue logic has
	// its edges: near-grey pixels sit around the no-colour threshold, ties
	// exercise the channel priority, and the extremes hit the widest spreads.
	task automatic queue_random_pixels(int count);
		int base, dev, kind, v, w;
		int ch [3];
		for (int n = 0; n < count; n++) begin
			kind = $urandom_range(0, 9);
			case (kind)
				4, 5: begin
					base = $urandom_range(0, 255);
					dev  = $urandom_range(0, 40);
					for (int c = 0; c < 3; c++) begin
						v = base + $urandom_range(0, 2 * dev) - dev;
						ch[c] = (v < 0) ? 0 : (v > 255) ? 255 : v;
					end
				end
				6: begin
					v = $urandom_range(0, 255);
					w = $urandom_range(0, 255);
					ch[0] = v;
					ch[1] = v;
					ch[2] = w;
					// Rotate so that the tied pair falls on any two channels.
					for (int k = $urandom_range(0, 2); k > 0; k--) begin
						v = ch[0];
						ch[0] = ch[1];
						ch[1] = ch[2];
						ch[2] = v;
					end
				end
				7: begin
					for (int c = 0; c < 3; c++) begin
						case ($urandom_range(0, 3))
							0: ch[c] = 0;
							1: ch[c] = 1;
							2: ch[c] = 254;
							default: ch[c] = 255;
						endcase
					end
				end
				8: begin
					// Very dark pixels, including black.
					for (int c = 0; c < 3; c++) ch[c] = $urandom_range(0, 3);
				end
				default: begin
					for (int c = 0; c < 3; c++) ch[c] = $urandom_range(0, 255);
				end
			endcase
			queue_pixel(ch[0], ch[1], ch[2]);
		end
	endtask

	// One register write, driven at a rising edge. The local copy follows the
	// block: indexes with no register behind them change nothing.
	task automatic put_bound(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		if (idx <= CFG_SAT_UPPER) bound_reg[idx] = value;
	endtask

	task automatic load_bounds(int hl, int hu, int il, int iu, int sl, int su, bit spare);
		put_bound(CFG_HUE_LOWER, 8'(hl));
		put_bound(CFG_HUE_UPPER, 8'(hu));
		put_bound(CFG_INT_LOWER, 8'(il));
		put_bound(CFG_INT_UPPER, 8'(iu));
		put_bound(CFG_SAT_LOWER, 8'(sl));
		put_bound(CFG_SAT_UPPER, 8'(su));
		if (spare) begin
			put_bound(SPARE_IDX_LO, 8'($urandom_range(0, 255)));
			put_bound(SPARE_IDX_HI, 8'($urandom_range(0, 255)));
		end
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Bounds that are mostly proper windows, now and then inverted or empty.
	task automatic load_random_bounds();
		int hl, hu, il, iu, sl, su;
		hl = $urandom_range(0, 200);
		hu = hl + $urandom_range(0, 90);
		if (hu > 255) hu = 255;
		il = $urandom_range(0, 180);
		iu = il + $urandom_range(0, 120);
		if (iu > 255) iu = 255;
		if ($urandom_range(0, 4) == 0) begin
			hl = hu;
			hu = $urandom_range(0, 255);
		end
		sl = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 255) : 0;
		su = $urandom_range(0, 255);
		load_bounds(hl, hu, il, iu, sl, su, $urandom_range(0, 1));
	endtask

	// Wait until every queued pixel has been taken and every result has come
	// back, then give the pipeline time to empty before the bounds change.
	task automatic drain();
		do @(negedge clk); while (pixel_q.size() != 0 || start || result_due_q.size() != 0);
		repeat (PIPE_SETTLE) @(negedge clk);
	endtask

	task automatic note_mismatch(string field, int want, int got);
		$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
		err_count++;
	endtask

	// Pixel driver. A pixel transaction completes at an edge where start is
	// high and busy is low; its expected result is worked out right there.
	// While busy holds a pixel off, start and the channels stay put.
	always @(posedge clk) begin
		pixel_t px;
		if (!arst_n) begin
			start    <= 1'b0;
			gap_left = 0;
		end else begin
			if (start && !busy) begin
				px.r = red;
				px.g = green;
				px.b = blue;
				result_due_q.push_back(hsi_of_pixel(px));
			end
			if (start && busy) begin
				// Held off: keep presenting the same pixel.
			end else if (gap_left > 0) begin
				start <= 1'b0;
				gap_left--;
			end else if (pixel_q.size() != 0 && gap_pct > 0
				&& $urandom_range(0, 99) < gap_pct) begin
				// This cycle is the first of a burst of idle cycles of random length.
				start    <= 1'b0;
				gap_left = $urandom_range(0, 3);
			end else if (pixel_q.size() != 0) begin
				px = pixel_q.pop_front();
				start <= 1'b1;
				red   <= px.r;
				green <= px.g;
				blue  <= px.b;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Result monitor. The block shows each result for one cycle only, so
	// every cycle with done high is a completed result transaction.
	always @(posedge clk) begin
		hsi_t want;
		if (arst_n && done) begin
			if (result_due_q.size() == 0) begin
				$display("%0t: result with none expected: expected none, actual hue %0d",
					$time, hue);
				err_count++;
			end else begin
				want = result_due_q.pop_front();
				if (hue !== want.hue) note_mismatch("hue", want.hue, hue);
				if (saturation !== want.saturation) begin
					note_mismatch("saturation", want.saturation, saturation);
				end
				if (intensity !== want.intensity) begin
					note_mismatch("intensity", want.intensity, intensity);
				end
				if (mask !== want.mask) note_mismatch("mask", want.mask, mask);
			end
		end
	end

	// Watchdog: any pixel transaction, result or register write counts as
	// progress; a long quiet stretch means the block has hung.
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_wr_en) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		err_count    = 0;
		quiet_cycles = 0;
		gap_pct      = 20;
		gap_left     = 0;
		bound_reg[CFG_HUE_LOWER] = RST_HUE_LOWER;
		bound_reg[CFG_HUE_UPPER] = RST_HUE_UPPER;
		bound_reg[CFG_INT_LOWER] = RST_INT_LOWER;
		bound_reg[CFG_INT_UPPER] = RST_INT_UPPER;
		bound_reg[CFG_SAT_LOWER] = RST_SAT_LOWER;
		bound_reg[CFG_SAT_UPPER] = RST_SAT_UPPER;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed pixels under the reset bounds. Black has a zero sum and
		// so no saturation; white and mid grey have no colour.
		queue_pixel(0, 0, 0);
		queue_pixel(255, 255, 255);
		queue_pixel(128, 128, 128);
		// Pure primaries and the smallest colourful pixels.
		queue_pixel(255, 0, 0);
		queue_pixel(0, 255, 0);
		queue_pixel(0, 0, 255);
		queue_pixel(1, 0, 0);
		queue_pixel(0, 1, 0);
		queue_pixel(0, 0, 1);
		// Ties for the largest channel: red beats green and blue, green beats blue.
		queue_pixel(200, 200, 0);
		queue_pixel(200, 0, 200);
		queue_pixel(0, 200, 200);
		queue_pixel(255, 255, 0);
		queue_pixel(0, 255, 255);
		// Either side of the no-colour threshold, where twice the spread meets the max.
		queue_pixel(100, 50, 50);
		queue_pixel(101, 50, 50);
		// Large channel differences of both signs; negative ones must truncate toward zero.
		queue_pixel(255, 0, 128);
		queue_pixel(255, 0, 255);
		queue_pixel(10, 200, 255);
		queue_pixel(254, 0, 255);
		queue_pixel(200, 0, 255);
		// A pixel that falls inside all the reset bounds.
		queue_pixel(150, 60, 30);
		queue_random_pixels(100);
		drain();

		// Bounds wide open, with writes to the unused indexes thrown in.
		load_bounds(0, 255, 0, 255, 0, 255, 1'b1);
		gap_pct = 10;
		queue_random_pixels(100);
		drain();

		// Fully inverted bounds: no pixel can match.
		load_bounds(255, 0, 255, 0, 255, 0, 1'b1);
		gap_pct = 30;
		queue_random_pixels(100);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			load_random_bounds();
			case ($urandom_range(0, 2))
				0: gap_pct = 0;
				1: gap_pct = 15;
				default: gap_pct = 35;
			endcase
			queue_random_pixels(110);
			drain();
		end

		// Last stretch at full rate with no idle cycles.
		load_random_bounds();
		gap_pct = 0;
		queue_random_pixels(100);
		drain();

		if (err_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
